FILE: rtl/ehzc_pkg.sv
// Shared widths, register indexes and types for the extent heat zone classifier.
package ehzc_pkg;

	// Field widths.
	localparam int TIME_W   = 64;
	localparam int REFC_W   = 32;
	localparam int CLASS_W  = 2;
	localparam int WEIGHT_W = 16;
	localparam int HEAT_W   = 16;
	localparam int ZONE_W   = 8;
	localparam int CFG_W    = 16;
	localparam int INDEX_W  = 3;

	// Score widths: read score tops out at 1024, rewrite score at 512, log2 at 31.
	localparam int RSCORE_W = 11;
	localparam int WSCORE_W = 10;
	localparam int SSCORE_W = 5;
	localparam logic [RSCORE_W-1:0] READ_CAP    = RSCORE_W'(1024);
	localparam logic [WSCORE_W-1:0] REWRITE_CAP = WSCORE_W'(512);

	// Zone mapping divider: numerator is heat times (zone_count - 1).
	localparam int NUM_W     = HEAT_W + ZONE_W;
	localparam int DIV_STEPS = ZONE_W;

	// Configuration register indexes.
	localparam logic [INDEX_W-1:0] REG_READ_WEIGHT     = INDEX_W'(0);
	localparam logic [INDEX_W-1:0] REG_SHARE_WEIGHT    = INDEX_W'(1);
	localparam logic [INDEX_W-1:0] REG_REWRITE_PENALTY = INDEX_W'(2);
	localparam logic [INDEX_W-1:0] REG_HEAT_LIMIT      = INDEX_W'(3);
	localparam logic [INDEX_W-1:0] REG_ZONE_COUNT      = INDEX_W'(4);

	// Data class of user or other data; every other class is metadata.
	localparam logic [CLASS_W-1:0] CLASS_USER       = CLASS_W'(0);
	localparam logic [CLASS_W-1:0] CLASS_BTREE      = CLASS_W'(1);
	localparam logic [CLASS_W-1:0] CLASS_SUPERBLOCK = CLASS_W'(2);
	localparam logic [CLASS_W-1:0] CLASS_JOURNAL    = CLASS_W'(3);

	// Data that rides alongside the divider.
	typedef struct packed {
		logic [HEAT_W-1:0] heat;
		logic              force_zero;
	} ehzc_side_t;

endpackage

FILE: rtl/ehzc_div.sv
// Pipelined restoring divider for the zone mapping, one quotient bit per stage.
module ehzc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        in_valid,
	input  logic [ehzc_pkg::NUM_W-1:0]  num,
	input  logic [ehzc_pkg::HEAT_W-1:0] den,
	input  ehzc_pkg::ehzc_side_t        in_side,
	output logic                        out_valid,
	output logic [ehzc_pkg::ZONE_W-1:0] quo,
	output ehzc_pkg::ehzc_side_t        out_side
);
	import ehzc_pkg::*;

	logic                 valid_s [0:DIV_STEPS-1];
	logic [NUM_W-1:0]     rem_s   [0:DIV_STEPS-2];
	logic [DIV_STEPS-1:0] quo_s   [0:DIV_STEPS-1];
	ehzc_side_t           side_s  [0:DIV_STEPS-1];

	// The quotient is known to fit in DIV_STEPS bits, since heat never exceeds the divisor.
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int BIT = DIV_STEPS - 1 - k;
		logic                 valid_in;
		logic [NUM_W-1:0]     rem_in;
		logic [DIV_STEPS-1:0] quo_in;
		ehzc_side_t           side_in;
		logic [NUM_W-1:0]     den_sh;
		logic                 fits;

		if (k == 0) begin : g_first
			assign valid_in = in_valid;
			assign rem_in   = num;
			assign quo_in   = '0;
			assign side_in  = in_side;
		end else begin : g_next
			assign valid_in = valid_s[k-1];
			assign rem_in   = rem_s[k-1];
			assign quo_in   = quo_s[k-1];
			assign side_in  = side_s[k-1];
		end

		// Trial subtraction of the divisor aligned to this quotient bit.
		assign den_sh = NUM_W'(den) << BIT;
		assign fits   = (rem_in >= den_sh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (advance) begin
				valid_s[k] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				quo_s[k]  <= {quo_in[DIV_STEPS-2:0], fits};
				side_s[k] <= side_in;
			end
		end

		// The last step needs no remainder.
		if (k < DIV_STEPS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (advance) begin
					rem_s[k] <= fits ? (rem_in - den_sh) : rem_in;
				end
			end
		end
	end

	assign out_valid = valid_s[DIV_STEPS-1];
	assign quo       = quo_s[DIV_STEPS-1];
	assign out_side  = side_s[DIV_STEPS-1];

endmodule

FILE: rtl/extent_heat_zone_classifier.sv
// Top level of the extent heat zone classifier: scoring pipeline, divider and output stage.
//
// Usage: each input transfer carries a bucket's last_read, last_write, refcount and
// data_class; each output transfer carries the target zone and the heat for that item,
// exactly one result per item and in the order taken.
// Both channels use valid and stall; a transfer happens on a rising edge with valid high
// and stall low. Configuration goes through cfg_we, cfg_index and cfg_data and is to be written
// by the user only while no item is in flight; the block itself does not enforce this.
// The pipeline holds 13 register stages: four scoring stages (scores, weight products,
// heat, zone numerator), eight divider stages that each resolve one quotient bit of the
// zone mapping, and the output register. Throughput is one item per cycle while the output
// is not stalled; the divider is fully pipelined.
// When the receiver stalls while a result is held, the whole pipeline freezes and in_stall
// is raised in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the registers with read_weight, share_weight and
// rewrite_penalty of 256, heat_limit of 1024 and zone_count of 2.
module extent_heat_zone_classifier (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ehzc_pkg::INDEX_W-1:0] cfg_index,
	input  logic [ehzc_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ehzc_pkg::TIME_W-1:0]  last_read,
	input  logic [ehzc_pkg::TIME_W-1:0]  last_write,
	input  logic [ehzc_pkg::REFC_W-1:0]  refcount,
	input  logic [ehzc_pkg::CLASS_W-1:0] data_class,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ehzc_pkg::ZONE_W-1:0]  zone,
	output logic [ehzc_pkg::HEAT_W-1:0]  heat
);
	import ehzc_pkg::*;

	// Configuration registers.
	logic [WEIGHT_W-1:0] read_weight_q;
	logic [WEIGHT_W-1:0] share_weight_q;
	logic [WEIGHT_W-1:0] rewrite_penalty_q;
	logic [HEAT_W-1:0]   heat_limit_q;
	logic [ZONE_W-1:0]   zone_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_weight_q     <= WEIGHT_W'(256);
			share_weight_q    <= WEIGHT_W'(256);
			rewrite_penalty_q <= WEIGHT_W'(256);
			heat_limit_q      <= HEAT_W'(1024);
			zone_count_q      <= ZONE_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_READ_WEIGHT:     read_weight_q     <= cfg_data;
				REG_SHARE_WEIGHT:    share_weight_q    <= cfg_data;
				REG_REWRITE_PENALTY: rewrite_penalty_q <= cfg_data;
				REG_HEAT_LIMIT:      heat_limit_q      <= cfg_data;
				REG_ZONE_COUNT:      zone_count_q      <= cfg_data[ZONE_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves unless a held result is stalled.
	logic valid_q;
	logic advance;

	assign advance  = !(valid_q && out_stall);
	assign in_stall = !advance;

	// Stage 1: time gaps, clamped scores and floor log2 of the refcount.
	logic [TIME_W:0]      gap_rw;
	logic [TIME_W-1:0]    gap_wr;
	logic                 write_newer;
	logic [RSCORE_W-1:0]  read_score;
	logic [WSCORE_W-1:0]  rewrite_score;
	logic [SSCORE_W-1:0]  share_score;

	assign gap_rw      = {1'b0, last_read} - {1'b0, last_write};
	assign gap_wr      = last_write - last_read;
	assign write_newer = gap_rw[TIME_W];

	always_comb begin
		read_score = '0;
		if (!gap_rw[TIME_W-1]) begin
			if (gap_rw[TIME_W-2:4] > (TIME_W-5)'(READ_CAP)) begin
				read_score = READ_CAP;
			end else begin
				read_score = gap_rw[RSCORE_W+3:4];
			end
		end
	end

	always_comb begin
		rewrite_score = '0;
		if (write_newer) begin
			if (gap_wr[TIME_W-1:4] > (TIME_W-4)'(REWRITE_CAP)) begin
				rewrite_score = REWRITE_CAP;
			end else begin
				rewrite_score = gap_wr[WSCORE_W+3:4];
			end
		end
	end

	// Leading-one position; zero and one both give zero.
	always_comb begin
		share_score = '0;
		for (int i = 1; i < REFC_W; i++) begin
			if (refcount[i]) begin
				share_score = SSCORE_W'(i);
			end
		end
	end

	logic                v_s1;
	logic [RSCORE_W-1:0] read_score_s1;
	logic [WSCORE_W-1:0] rewrite_score_s1;
	logic [SSCORE_W-1:0] share_score_s1;
	logic                user_s1;

	// Stage 2: weighted scores.
	localparam int PREAD_W  = WEIGHT_W + RSCORE_W;
	localparam int PSHARE_W = WEIGHT_W + SSCORE_W;
	localparam int PPEN_W   = WEIGHT_W + WSCORE_W;

	logic                v_s2;
	logic [PREAD_W-1:0]  prod_read_s2;
	logic [PSHARE_W-1:0] prod_share_s2;
	logic [PPEN_W-1:0]   prod_pen_s2;
	logic                user_s2;

	// Stage 3: heat after penalty and cap.
	localparam int SUM_W = PSHARE_W + 9;
	localparam int RAW_W = SUM_W - 8;

	logic [SUM_W-1:0]  heat_sum;
	logic [RAW_W-1:0]  heat_raw;
	logic [RAW_W-1:0]  penalty;
	logic [RAW_W-1:0]  heat_net;
	logic [HEAT_W-1:0] heat_capped;

	assign heat_sum = SUM_W'(prod_read_s2) + {1'b0, prod_share_s2, 8'b0};
	assign heat_raw = heat_sum[SUM_W-1:8];
	assign penalty  = RAW_W'(prod_pen_s2[PPEN_W-1:8]);
	assign heat_net = (heat_raw > penalty) ? (heat_raw - penalty) : '0;
	assign heat_capped = (heat_net > RAW_W'(heat_limit_q)) ? heat_limit_q
	                                                       : heat_net[HEAT_W-1:0];

	logic              v_s3;
	logic [HEAT_W-1:0] heat_s3;
	logic              user_s3;

	// Stage 4: zone numerator and the forced-zero cases.
	logic [ZONE_W-1:0] zone_top;

	assign zone_top = zone_count_q - ZONE_W'(1);

	logic              v_s4;
	logic [NUM_W-1:0]  num_s4;
	ehzc_side_t        side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_score_s1      <= read_score;
			rewrite_score_s1   <= rewrite_score;
			share_score_s1     <= share_score;
			user_s1            <= (data_class == CLASS_USER);
			prod_read_s2       <= read_weight_q * read_score_s1;
			prod_share_s2      <= share_weight_q * share_score_s1;
			prod_pen_s2        <= rewrite_penalty_q * rewrite_score_s1;
			user_s2            <= user_s1;
			heat_s3            <= heat_capped;
			user_s3            <= user_s2;
			num_s4             <= heat_s3 * zone_top;
			side_s4.heat       <= heat_s3;
			side_s4.force_zero <= !user_s3 || (zone_count_q == '0);
		end
	end

	// Stages 5 to 12: zone mapping quotient.
	logic              div_valid;
	logic [ZONE_W-1:0] div_quo;
	ehzc_side_t        div_side;

	ehzc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (v_s4),
		.num       (num_s4),
		.den       (heat_limit_q),
		.in_side   (side_s4),
		.out_valid (div_valid),
		.quo       (div_quo),
		.out_side  (div_side)
	);

	// Output stage: the zone counts inward from the innermost zone; a zero limit gives quotient 0.
	logic [ZONE_W-1:0] zone_next;
	logic [ZONE_W-1:0] zone_q;
	logic [HEAT_W-1:0] heat_q;

	always_comb begin
		if (div_side.force_zero) begin
			zone_next = '0;
		end else if (heat_limit_q == '0) begin
			zone_next = zone_top;
		end else begin
			zone_next = zone_top - div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			zone_q <= zone_next;
			heat_q <= div_side.heat;
		end
	end

	assign out_valid = valid_q;
	assign zone      = zone_q;
	assign heat      = heat_q;

`ifndef SYNTHESIS
	// The heat never exceeds the configured limit.
	a_heat_cap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (heat_q <= heat_limit_q))
		else $error("heat above heat_limit");

	// An unset zone count always maps to zone zero.
	a_zone_unset: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (zone_count_q == '0)) |-> (zone_q == '0))
		else $error("nonzero zone with zone_count unset");

	// A zone is always inside the configured range.
	a_zone_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (zone_count_q != '0)) |-> (zone_q < zone_count_q))
		else $error("zone out of range");

	// Input is held back only while a result is waiting at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_q && out_stall))
		else $error("input stalled without a held result");

	// An accepted item occupies the first stage on the next cycle.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted item lost at stage 1");
`endif

endmodule

FILE: tb/tb_extent_heat_zone_classifier.sv
// Self-checking testbench for the extent heat zone classifier, with driver, monitor and predictor.
module tb_extent_heat_zone_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	import ehzc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int IDLE_PERCENT = 35;
	localparam int CALM_START = 1500;
	localparam int CALM_END = 2500;
	localparam int HOLD_AFTER = 500;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 30;

	// One bucket description as it enters the block.
	typedef struct {
		logic [TIME_W-1:0]  rd;
		logic [TIME_W-1:0]  wr;
		logic [REFC_W-1:0]  refs;
		logic [CLASS_W-1:0] cls;
	} bucket_t;

	// Zone and heat that the block should return for one bucket.
	typedef struct {
		logic [ZONE_W-1:0] zone;
		logic [HEAT_W-1:0] heat;
	} placement_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [INDEX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [TIME_W-1:0]    last_read = '0;
	logic [TIME_W-1:0]    last_write = '0;
	logic [REFC_W-1:0]    refcount = '0;
	logic [CLASS_W-1:0]   data_class = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [ZONE_W-1:0]    zone;
	logic [HEAT_W-1:0]    heat;

	// Shadow copy of the configuration registers.
	logic [WEIGHT_W-1:0]  read_weight_q = 16'd256;
	logic [WEIGHT_W-1:0]  share_weight_q = 16'd256;
	logic [WEIGHT_W-1:0]  rewrite_penalty_q = 16'd256;
	logic [HEAT_W-1:0]    heat_limit_q = 16'd1024;
	logic [ZONE_W-1:0]    zone_count_q = 8'd2;

	bucket_t    pending_buckets[$];
	placement_t expected_placements[$];
	bucket_t    offered;
	int         cycle_count = 0;
	int         mismatch_count = 0;
	int         placements_seen = 0;
	int         hold_left = 0;
	bit         hold_done = 1'b0;

	extent_heat_zone_classifier u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.last_read(last_read),
		.last_write(last_write),
		.refcount(refcount),
		.data_class(data_class),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.zone(zone),
		.heat(heat)
	);

	always #5 clk = ~clk;

	// Heat scoring and zone mapping for one bucket under the current registers.
	function automatic placement_t predict_placement(bucket_t b);
		logic [63:0] gap;
		logic [63:0] recency;
		logic [63:0] sharing;
		logic [63:0] churn;
		logic [63:0] warmth;
		logic [63:0] penalty;
		logic [63:0] span;
		logic [63:0] quot;
		placement_t  p;
		gap = b.rd - b.wr;
		recency = 64'd0;
		if (!gap[63]) begin
			recency = gap >> 4;
			if (recency > 64'd1024)
				recency = 64'd1024;
		end
		sharing = 64'd0;
		for (int i = 1; i < REFC_W; i++) begin
			if (b.refs[i])
				sharing = 64'(i);
		end
		churn = 64'd0;
		if (b.wr > b.rd) begin
			churn = (b.wr - b.rd) >> 4;
			if (churn > 64'd512)
				churn = 64'd512;
		end
		warmth = (64'(read_weight_q) * recency + 64'(share_weight_q) * sharing * 64'd256) >> 8;
		penalty = (64'(rewrite_penalty_q) * churn) >> 8;
		warmth = (warmth > penalty) ? warmth - penalty : 64'd0;
		if (warmth > 64'(heat_limit_q))
			warmth = 64'(heat_limit_q);
		p.zone = '0;
		if (b.cls == CLASS_USER && zone_count_q != 0) begin
			span = 64'(zone_count_q) - 64'd1;
			quot = (heat_limit_q != 0) ? (warmth * span) / 64'(heat_limit_q) : 64'd0;
			p.zone = ZONE_W'((quot <= span) ? span - quot : 64'd0);
		end
		p.heat = HEAT_W'(warmth);
		return p;
	endfunction

	// Each side idles about a third of the time, except in one calm window.
	function automatic bit take_break();
		if (cycle_count >= CALM_START && cycle_count < CALM_END)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PERCENT;
	endfunction

	// Random bucket, mostly with time gaps near the score ranges.
	function automatic bucket_t random_bucket();
		bucket_t b;
		int      kind;
		b.rd = {$urandom, $urandom};
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3: begin
				b.wr = b.rd - 64'($urandom_range(0, 20000));
			end
			4, 5, 6: begin
				b.wr = b.rd + 64'($urandom_range(0, 10000));
			end
			7: begin
				b.wr = {$urandom, $urandom};
			end
			8: begin
				b.wr = b.rd + (64'h1 << 63) + 64'($urandom_range(0, 40)) - 64'd20;
			end
			default: begin
				b.wr = b.rd;
			end
		endcase
		case ($urandom_range(0, 9))
			0: b.refs = REFC_W'($urandom_range(0, 1));
			default: b.refs = $urandom >> $urandom_range(0, 31);
		endcase
		b.cls = ($urandom_range(0, 9) < 7) ? CLASS_USER : CLASS_W'($urandom_range(0, 3));
		return b;
	endfunction

	task automatic queue_bucket(logic [63:0] rd, logic [63:0] wr, logic [31:0] refs,
			logic [1:0] cls);
		bucket_t b;
		b.rd = rd;
		b.wr = wr;
		b.refs = refs;
		b.cls = cls;
		pending_buckets.push_back(b);
	endtask

	// One register write; the shadow copy follows since the block is idle.
	task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_READ_WEIGHT:     read_weight_q = value;
			REG_SHARE_WEIGHT:    share_weight_q = value;
			REG_REWRITE_PENALTY: rewrite_penalty_q = value;
			REG_HEAT_LIMIT:      heat_limit_q = value;
			REG_ZONE_COUNT:      zone_count_q = ZONE_W'(value);
			default: ;
		endcase
	endtask

	task automatic load_settings(int rw, int sw, int pw, int hl, int zc);
		write_reg(REG_READ_WEIGHT, CFG_W'(rw));
		write_reg(REG_SHARE_WEIGHT, CFG_W'(sw));
		write_reg(REG_REWRITE_PENALTY, CFG_W'(pw));
		write_reg(REG_HEAT_LIMIT, CFG_W'(hl));
		write_reg(REG_ZONE_COUNT, CFG_W'(zc));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every queued bucket went in and every placement came back.
	// Sampling on the falling edge sees the settled state of the last rising edge.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_buckets.size() != 0 || in_valid || expected_placements.size() != 0);
	endtask

	// Driver: offers queued buckets and records the expected placement on each transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			last_read <= '0;
			last_write <= '0;
			refcount <= '0;
			data_class <= '0;
		end else begin
			if (in_valid && !in_stall)
				expected_placements.push_back(predict_placement(offered));
			if (!in_valid || !in_stall) begin
				if (pending_buckets.size() != 0 && !take_break()) begin
					offered = pending_buckets.pop_front();
					last_read <= offered.rd;
					last_write <= offered.wr;
					refcount <= offered.refs;
					data_class <= offered.cls;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Hold-off counter: one long receiver stall once enough results came back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && placements_seen >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks each output transfer and drives the receiver's stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				placements_seen++;
				if (expected_placements.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result, zone %0d heat %0d", $time, zone, heat);
				end else begin
					if (zone !== expected_placements[0].zone) begin
						mismatch_count++;
						$display("%0t: zone mismatch, expected %0d, actual %0d", $time,
							expected_placements[0].zone, zone);
					end
					if (heat !== expected_placements[0].heat) begin
						mismatch_count++;
						$display("%0t: heat mismatch, expected %0d, actual %0d", $time,
							expected_placements[0].heat, heat);
					end
					void'(expected_placements.pop_front());
				end
			end
			// The long hold-off lets the pipeline fill and back up into the input.
			if (hold_left > 0) begin
				out_stall <= 1'b1;
			end else begin
				out_stall <= take_break();
			end
		end
	end

	// Cycle counter with a timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Stimulus: directed buckets under reset settings, then phases of random buckets under a series of settings.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Equal times, all-ones and wrapped gaps, score caps and their edges.
		queue_bucket(64'd0, 64'd0, 32'd0, CLASS_USER);
		queue_bucket('1, 64'd0, 32'd1, CLASS_USER);
		queue_bucket(64'd0, '1, 32'd2, CLASS_USER);
		queue_bucket(64'd16384, 64'd0, 32'd3, CLASS_USER);
		queue_bucket(64'd16400, 64'd0, 32'd4, CLASS_USER);
		queue_bucket(64'd16399, 64'd0, 32'd0, CLASS_USER);
		queue_bucket(64'd15, 64'd0, 32'd0, CLASS_USER);
		queue_bucket(64'd0, 64'h8000_0000_0000_0000, 32'd0, CLASS_USER);
		queue_bucket(64'h8000_0000_0000_0000, 64'd0, 32'd0, CLASS_USER);
		queue_bucket(64'd0, 64'h8000_0000_0000_0001, 32'd0, CLASS_USER);
		queue_bucket(64'd100, 64'd100 + 64'd8192, 32'd0, CLASS_USER);
		queue_bucket(64'd100, 64'd100 + 64'd8208, 32'd0, CLASS_USER);
		queue_bucket(64'd100, 64'd100 + 64'd15, 32'd0, CLASS_USER);
		queue_bucket(64'd4000, 64'd0, 32'h8000_0000, CLASS_USER);
		queue_bucket(64'd4000, 64'd0, 32'hFFFF_FFFF, CLASS_USER);
		queue_bucket(64'd2000, 64'd0, 32'd7, CLASS_USER);
		queue_bucket(64'd0, 64'd500, 32'd64, CLASS_USER);
		// Metadata classes still report heat but always target zone zero.
		queue_bucket(64'd20000, 64'd0, 32'd1024, CLASS_BTREE);
		queue_bucket(64'd20000, 64'd0, 32'd1024, CLASS_SUPERBLOCK);
		queue_bucket(64'd20000, 64'd0, 32'd1024, CLASS_JOURNAL);
		queue_bucket('1, '1, 32'hFFFF_FFFF, CLASS_JOURNAL);
		drain();

		// Extremes, heat limit of zero, unset zone count, then random settings.
		for (int phase = 0; phase < 13; phase++) begin
			case (phase)
				0: load_settings(65535, 65535, 65535, 65535, 255);
				1: load_settings(0, 0, 0, 1, 1);
				2: load_settings(256, 256, 256, 0, 17);
				3: load_settings(512, 128, 300, 700, 0);
				4: load_settings(256, 256, 256, 1, 255);
				default: load_settings($urandom_range(0, 65535) >> $urandom_range(0, 8),
					$urandom_range(0, 65535) >> $urandom_range(0, 10),
					$urandom_range(0, 65535) >> $urandom_range(0, 8),
					$urandom_range(1, 65535) >> $urandom_range(0, 6) | 1,
					$urandom_range(0, 255));
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				pending_buckets.push_back(random_bucket());
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ehzc_pkg.sv
rtl/ehzc_div.sv
rtl/extent_heat_zone_classifier.sv
tb/tb_extent_heat_zone_classifier.sv
